@@ hdl/lseg_pkg.sv @@
// package for the led strip effect generator
// holds widths, register indexes, effect codes and payload types; no dependencies
`timescale 1ns / 1ps
package lseg_pkg;
  localparam int TimeWidthDefault = 32;
  localparam int NowW = 32;
  localparam int RegIdxW = 2;
  localparam int RegDataW = 16;

  typedef enum logic [RegIdxW-1:0] {
    REG_MODE = 2'd0,
    REG_BRIGHT = 2'd1,
    REG_PERIOD = 2'd2,
    REG_ENABLE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_STATIC = 3'd0,
    MODE_BLINK = 3'd1,
    MODE_PULSE = 3'd2,
    MODE_STROBE = 3'd3,
    MODE_CHASE = 3'd4,
    MODE_HUE = 3'd5,
    MODE_AUDIO = 3'd6,
    MODE_OFF = 3'd7
  } mode_t;

  typedef struct packed {
    logic [NowW-1:0] now_ms;
    logic [7:0] audio_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic write_duty;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0] index;
    logic [RegDataW-1:0] data;
  } cfg_item_t;

  // settings captured alongside each item
  typedef struct packed {
    mode_t mode;
    logic [7:0] bright;
    logic enable;
    logic [7:0] audio;
  } ctl_t;
endpackage

@@ hdl/lseg_stream_if.sv @@
// valid/ready channel interface
// depends on nothing; payload type set per instance
`timescale 1ns / 1ps
interface lseg_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lseg_div.sv @@
// pipelined unsigned divider, one quotient bit per stage
// depends on nothing; widths are passed in as parameters
`timescale 1ns / 1ps
module lseg_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input logic clk,
  input logic rst,
  input logic en,
  input logic in_valid,
  input logic [NW-1:0] num,
  input logic [DW-1:0] den,
  input logic [SW-1:0] side_in,
  output logic out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);
  logic [NW-1:0] q [NW+1];
  logic [DW-1:0] r [NW+1];
  logic [DW-1:0] d [NW+1];
  logic [SW-1:0] s [NW+1];
  logic v [NW+1];

  assign q[0] = num;
  assign r[0] = '0;
  assign d[0] = den;
  assign s[0] = side_in;
  assign v[0] = in_valid;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic ge;
    assign shifted = {r[i], q[i][NW-1]};
    assign diff = shifted - {1'b0, d[i]};
    assign ge = shifted >= {1'b0, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= {q[i][NW-2:0], ge};
        r[i+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        d[i+1] <= d[i];
        s[i+1] <= s[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end
  end

  assign out_valid = v[NW];
  assign quo = q[NW];
  assign side_out = s[NW];
endmodule

@@ hdl/lseg_shape.sv @@
// effect shaping stages after the division: phase reduction, scaling, output
// depends on lseg_pkg
`timescale 1ns / 1ps
module lseg_shape #(
  parameter int TW = 32
) (
  input logic clk,
  input logic rst,
  input logic en,
  input logic in_valid,
  input logic [TW-1:0] qp,
  input logic [TW-1:0] q10,
  input logic [TW-1:0] q256,
  input lseg_pkg::ctl_t ctl,
  output logic out_valid,
  output lseg_pkg::out_item_t res
);
  // 12-bit chunks; 4096 leaves remainder one both modulo 45 and modulo 5
  localparam int NH = (TW - 3 + 11) / 12;
  localparam int NC = (TW - 2 + 11) / 12;

  // stage r: chunk sums of the quotients, folded once
  logic [12*NH-1:0] hpad;
  logic [12*NC-1:0] cpad;
  logic [15:0] hsum_c;
  logic [15:0] csum_c;
  logic [12:0] hf_c;
  logic [12:0] cf_c;
  logic vr;
  lseg_pkg::ctl_t cr;
  logic [12:0] hf;
  logic [12:0] cf;
  logic [2:0] hlo_r;
  logic [1:0] clo_r;
  logic [8:0] pls_r;
  logic blk_r;
  logic stb_r;
  // stage s: reciprocal quotients by 45 and by 5
  logic [27:0] hmul;
  logic [26:0] cmul;
  logic vs;
  lseg_pkg::ctl_t cs;
  logic [12:0] hf_s;
  logic [12:0] cf_s;
  logic [7:0] hq;
  logic [9:0] cq;
  logic [2:0] hlo_s;
  logic [1:0] clo_s;
  logic [8:0] pls_s;
  logic blk_s;
  logic stb_s;
  logic [12:0] hrem;
  logic [12:0] crem;
  // stage a: reduce quotients to phases
  logic va;
  lseg_pkg::ctl_t ca;
  logic [8:0] hue;
  logic [8:0] pls;
  logic [4:0] chs;
  logic blk;
  logic stb;
  // stage b: multiply
  logic vb;
  lseg_pkg::ctl_t cb;
  logic [16:0] prod;
  logic [1:0] seg;
  // stage c: divide by constant and pick
  logic [7:0] num8;
  logic [8:0] x9;
  logic [33:0] p10m;
  logic [28:0] p120m;
  logic [7:0] d;

  // hue phase: low three bits kept, the rest reduced modulo 45
  // chase phase: low two bits kept, the rest reduced modulo 5
  always_comb begin
    hpad = '0;
    hpad[TW-4:0] = qp[TW-1:3];
    cpad = '0;
    cpad[TW-3:0] = q10[TW-1:2];
    hsum_c = '0;
    csum_c = '0;
    for (int i = 0; i < NH; i++) hsum_c = hsum_c + 16'(hpad[12*i +: 12]);
    for (int i = 0; i < NC; i++) csum_c = csum_c + 16'(cpad[12*i +: 12]);
    hf_c = 13'(hsum_c[11:0]) + 13'(hsum_c[15:12]);
    cf_c = 13'(csum_c[11:0]) + 13'(csum_c[15:12]);
  end

  assign hmul = 28'(hf) * 28'd23302;
  assign cmul = 27'(cf) * 27'd13108;
  assign hrem = hf_s - (13'(hq) * 13'd45);
  assign crem = cf_s - (13'(cq) * 13'd5);

  always_comb begin
    x9 = 9'd0;
    unique case (ca.mode)
      lseg_pkg::MODE_PULSE: x9 = (pls < 9'd256) ? pls : 9'(10'd512 - {1'b0, pls});
      lseg_pkg::MODE_CHASE: x9 = {4'd0, (chs < 5'd10) ? chs : 5'd20 - chs};
      lseg_pkg::MODE_HUE: begin
        if (hue < 9'd120) x9 = hue;
        else if (hue < 9'd240) x9 = hue - 9'd120;
        else x9 = hue - 9'd240;
      end
      default: x9 = 9'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
      vs <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vr <= in_valid;
      vs <= vr;
      va <= vs;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr <= ctl;
      hf <= hf_c;
      cf <= cf_c;
      hlo_r <= qp[2:0];
      clo_r <= q10[1:0];
      pls_r <= q256[8:0];
      blk_r <= qp[0];
      stb_r <= q10[0];
      cs <= cr;
      hf_s <= hf;
      cf_s <= cf;
      hq <= hmul[27:20];
      cq <= cmul[25:16];
      hlo_s <= hlo_r;
      clo_s <= clo_r;
      pls_s <= pls_r;
      blk_s <= blk_r;
      stb_s <= stb_r;
      ca <= cs;
      hue <= {hrem[5:0], hlo_s};
      pls <= pls_s;
      chs <= {crem[2:0], clo_s};
      blk <= blk_s;
      stb <= stb_s;
      cb <= ca;
      prod <= x9 * ca.bright;
      if (ca.mode == lseg_pkg::MODE_BLINK) seg <= {1'b1, blk};
      else if (ca.mode == lseg_pkg::MODE_STROBE) seg <= {1'b1, stb};
      else seg <= (hue >= 9'd120 && hue < 9'd240) ? 2'd1 : 2'd0;
      res <= '{duty: d, write_duty: cb.enable};
    end
  end

  // divide by 10 and by 120 through reciprocal multiplication
  assign p10m = 34'(prod) * 34'd52429;
  assign p120m = 29'(prod[16:3]) * 29'd17477;

  always_comb begin
    num8 = 8'd0;
    d = 8'd0;
    unique case (cb.mode)
      lseg_pkg::MODE_STATIC: d = cb.bright;
      lseg_pkg::MODE_BLINK: d = seg[0] ? 8'd0 : cb.bright;
      lseg_pkg::MODE_STROBE: d = seg[0] ? 8'd0 : 8'd255;
      lseg_pkg::MODE_PULSE: d = (prod >= 17'h10000) ? 8'd255 : prod[15:8];
      lseg_pkg::MODE_CHASE: d = p10m[26:19];
      lseg_pkg::MODE_HUE: begin
        num8 = p120m[25:18];
        d = seg[0] ? cb.bright - num8 : num8;
      end
      lseg_pkg::MODE_AUDIO: d = cb.audio;
      default: d = 8'd0;
    endcase
    if (!cb.enable) d = 8'd0;
  end
endmodule

@@ hdl/led_strip_effect_generator.sv @@
// top level of the led strip effect generator
// depends on lseg_pkg, lseg_stream_if, lseg_div, lseg_shape
`timescale 1ns / 1ps
// usage
// - in channel: a transaction brings now_ms and audio_level
// - out channel: one transaction per input with duty and write_duty
// - cfg channel: index/data writes to mode, brightness, period, enable;
//   always ready; to be written only while the block is idle (unchecked)
// - the low TIME_WIDTH bits of now_ms are divided by the period, the period
//   over ten and the period over 256 in three pipelined dividers, one
//   quotient bit per stage, then five shaping stages (chunk fold, reciprocal
//   quotient, phase, multiply, output)
// - one item per cycle unless stalled; the divider pipeline sets the latency
// - the whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver freezes everything and nothing is lost
// - a zero divisor counts as one
// - reset clears the valid bits and loads mode static, brightness 255,
//   period 100 and strip disabled
// - disabled strip gives duty 0 and write_duty 0
module led_strip_effect_generator #(
  parameter int TIME_WIDTH = lseg_pkg::TimeWidthDefault
) (
  input logic clk,
  input logic rst,
  lseg_stream_if.sink in_ch,
  lseg_stream_if.sink cfg,
  lseg_stream_if.source out_ch
);
  localparam int TW = TIME_WIDTH;
  localparam int CW = $bits(lseg_pkg::ctl_t);

  lseg_pkg::mode_t mode;
  logic [7:0] bright;
  logic [15:0] period;
  logic enable;
  logic en;
  logic [TW-1:0] t;
  logic [15:0] dp, d10, d256, p10, p256;
  logic [31:0] p10m;
  logic [TW-1:0] qp, q10, q256;
  logic vdiv, v10u, v256u;
  lseg_pkg::ctl_t cin, cdiv;
  lseg_pkg::in_item_t ii;
  lseg_pkg::cfg_item_t cw;
  logic [CW-1:0] cdiv_bits;
  logic [0:0] s10u, s256u;

  assign ii = in_ch.data;
  assign cw = cfg.data;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lseg_pkg::MODE_STATIC;
      bright <= 8'd255;
      period <= 16'd100;
      enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (lseg_pkg::reg_idx_t'(cw.index))
        lseg_pkg::REG_MODE: mode <= lseg_pkg::mode_t'(cw.data[2:0]);
        lseg_pkg::REG_BRIGHT: bright <= cw.data[7:0];
        lseg_pkg::REG_PERIOD: period <= cw.data;
        lseg_pkg::REG_ENABLE: enable <= cw.data[0];
        default: ;
      endcase
    end
  end

  // period over ten by reciprocal multiplication, exact for 16-bit periods
  assign p10m = 32'(period) * 32'd52429;
  assign p10 = p10m[31:19] == 13'd0 ? 16'd0 : 16'(p10m[31:19]);
  assign p256 = period >> 8;
  assign dp = (period == 16'd0) ? 16'd1 : period;
  assign d10 = (p10 == 16'd0) ? 16'd1 : p10;
  assign d256 = (p256 == 16'd0) ? 16'd1 : p256;

  if (TW >= lseg_pkg::NowW) begin : g_tw
    assign t = TW'(ii.now_ms);
  end else begin : g_tn
    assign t = ii.now_ms[TW-1:0];
  end

  assign cin = '{mode: mode, bright: bright, enable: enable, audio: ii.audio_level};

  lseg_div #(.NW(TW), .DW(16), .SW(CW)) u_div_p (
    .clk, .rst, .en, .in_valid(in_ch.valid), .num(t), .den(dp),
    .side_in(cin), .out_valid(vdiv), .quo(qp), .side_out(cdiv_bits)
  );
  lseg_div #(.NW(TW), .DW(16), .SW(1)) u_div_10 (
    .clk, .rst, .en, .in_valid(in_ch.valid), .num(t), .den(d10),
    .side_in(1'b0), .out_valid(v10u), .quo(q10), .side_out(s10u)
  );
  lseg_div #(.NW(TW), .DW(16), .SW(1)) u_div_256 (
    .clk, .rst, .en, .in_valid(in_ch.valid), .num(t), .den(d256),
    .side_in(1'b0), .out_valid(v256u), .quo(q256), .side_out(s256u)
  );
  assign cdiv = lseg_pkg::ctl_t'(cdiv_bits);

  lseg_shape #(.TW(TW)) u_shape (
    .clk, .rst, .en, .in_valid(vdiv & (v10u | s10u[0] | ~s10u[0]) & (v256u | ~s256u[0])),
    .qp, .q10, .q256, .ctl(cdiv), .out_valid(out_ch.valid), .res(out_ch.data)
  );
endmodule

@@ hdl/lseg_checker.sv @@
// port-level checker for the led strip effect generator
// depends on lseg_pkg; bound to the top level
`timescale 1ns / 1ps
module lseg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input lseg_pkg::out_item_t out_data
);
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result lost");
  // disabled strip never carries a duty
  a_dis: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_duty |-> out_data.duty == 8'd0) else $error("duty leak");
  // input accepted whenever output side free
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("needless stall");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("valid after reset");
endmodule

bind led_strip_effect_generator lseg_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

@@ dv/led_strip_effect_generator_test.sv @@
// self-checking testbench for the led strip effect generator
// depends on lseg_pkg, lseg_stream_if and the led_strip_effect_generator rtl
`timescale 1ns / 1ps
module led_strip_effect_generator_test;
  logic clk = 1'b0;
  logic rst = 1'b1;

  lseg_stream_if #(.payload_t(lseg_pkg::in_item_t)) in_ch (clk);
  lseg_stream_if #(.payload_t(lseg_pkg::cfg_item_t)) cfg (clk);
  lseg_stream_if #(.payload_t(lseg_pkg::out_item_t)) out_ch (clk);

  led_strip_effect_generator dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .cfg(cfg.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the register file, updated on each cfg transaction
  logic [2:0] cur_mode;
  logic [7:0] cur_bright;
  logic [15:0] cur_period;
  logic cur_enable;

  lseg_pkg::out_item_t duty_queue[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int send_gap = 0;   // sender idle percentage
  int take_gap = 0;   // receiver stall percentage

  // duty predictor; every divisor of zero becomes one
  function automatic lseg_pkg::out_item_t predict_duty(logic [31:0] t, logic [7:0] audio);
    lseg_pkg::out_item_t r;
    longint unsigned b, p, p10, p256, x, tt;
    logic [7:0] d;
    tt = 64'(t);
    b = 64'(cur_bright);
    p = (cur_period == 16'd0) ? 64'd1 : 64'(cur_period);
    p10 = (cur_period / 16'd10 == 16'd0) ? 64'd1 : 64'(cur_period / 16'd10);
    p256 = (cur_period / 16'd256 == 16'd0) ? 64'd1 : 64'(cur_period / 16'd256);
    d = 8'd0;
    case (lseg_pkg::mode_t'(cur_mode))
      lseg_pkg::MODE_STATIC: d = 8'(b);
      lseg_pkg::MODE_BLINK: d = ((tt / p) % 2 == 0) ? 8'(b) : 8'd0;
      lseg_pkg::MODE_PULSE: begin
        x = (tt / p256) % 512;
        d = (x < 256) ? 8'((x * b) / 256) : 8'(((512 - x) * b) / 256);
      end
      lseg_pkg::MODE_STROBE: d = ((tt / p10) % 2 == 0) ? 8'd255 : 8'd0;
      lseg_pkg::MODE_CHASE: begin
        x = (tt / p10) % 20;
        d = (x < 10) ? 8'((x * b) / 10) : 8'(((20 - x) * b) / 10);
      end
      lseg_pkg::MODE_HUE: begin
        x = (tt / p) % 360;
        if (x < 120) d = 8'((x * b) / 120);
        else if (x < 240) d = 8'(b - ((x - 120) * b) / 120);
        else d = 8'(((x - 240) * b) / 120);
      end
      lseg_pkg::MODE_AUDIO: d = audio;
      default: d = 8'd0;
    endcase
    r.duty = cur_enable ? d : 8'd0;
    r.write_duty = cur_enable;
    return r;
  endfunction

  // result checker and randomised receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (duty_queue.size() == 0) begin
          $display("%0t: unexpected transaction, actual %p", $time, out_ch.data);
          errors++;
        end else begin
          lseg_pkg::out_item_t want;
          want = duty_queue.pop_front();
          checked++;
          if (out_ch.data.duty !== want.duty) begin
            $display("%0t: duty expected %0d actual %0d", $time, want.duty,
                     out_ch.data.duty);
            errors++;
          end
          if (out_ch.data.write_duty !== want.write_duty) begin
            $display("%0t: write_duty expected %0b actual %0b", $time,
                     want.write_duty, out_ch.data.write_duty);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= take_gap);
    end
  end

  // register write; the local copy follows at the accepting edge
  // valid stays up so that writes can follow back to back
  task automatic write_reg(lseg_pkg::reg_idx_t idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, data: value};
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      lseg_pkg::REG_MODE: cur_mode = value[2:0];
      lseg_pkg::REG_BRIGHT: cur_bright = value[7:0];
      lseg_pkg::REG_PERIOD: cur_period = value;
      default: cur_enable = value[0];
    endcase
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain;
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_all(logic [2:0] m, logic [7:0] b, logic [15:0] p, logic e);
    drain();
    write_reg(lseg_pkg::REG_MODE, 16'(m));
    write_reg(lseg_pkg::REG_BRIGHT, 16'(b));
    write_reg(lseg_pkg::REG_PERIOD, p);
    write_reg(lseg_pkg::REG_ENABLE, 16'(e));
    cfg.valid <= 1'b0;
  endtask

  // one input transaction, with an optional idle gap first; the expectation
  // is queued at the accepting edge before the checker could see the result
  task automatic send_item(logic [31:0] t, logic [7:0] audio);
    while ($urandom_range(99) < send_gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{now_ms: t, audio_level: audio};
    do @(posedge clk); while (!in_ch.ready);
    duty_queue.push_back(predict_duty(t, audio));
    sent++;
  endtask

  task automatic send_idle;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // directed rows: configuration then one item; where the answer is obvious
  // it is typed in and compared with the predictor as well
  typedef struct {
    logic [2:0] mode;
    logic [7:0] bright;
    logic [15:0] period;
    logic enable;
    logic [31:0] now;
    logic [7:0] audio;
    bit known;
    logic [7:0] duty;
  } row_t;

  row_t rows[] = '{
    '{lseg_pkg::MODE_STATIC, 8'd255, 16'd100, 1'b0, 32'd0, 8'd0, 1, 8'd0},  // after reset
    '{lseg_pkg::MODE_STATIC, 8'd255, 16'd100, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1, 8'd255},
    '{lseg_pkg::MODE_STATIC, 8'd0, 16'd100, 1'b1, 32'd5, 8'd1, 1, 8'd0},
    '{lseg_pkg::MODE_BLINK, 8'd200, 16'd100, 1'b1, 32'd99, 8'd0, 1, 8'd200},
    '{lseg_pkg::MODE_BLINK, 8'd200, 16'd100, 1'b1, 32'd100, 8'd0, 1, 8'd0},
    '{lseg_pkg::MODE_BLINK, 8'd200, 16'd0, 1'b1, 32'd3, 8'd0, 1, 8'd0},     // zero period
    '{lseg_pkg::MODE_PULSE, 8'd255, 16'd1, 1'b1, 32'd255, 8'd0, 0, 8'd0},   // period/256 zero
    '{lseg_pkg::MODE_PULSE, 8'd255, 16'd512, 1'b1, 32'd512, 8'd0, 0, 8'd0},
    '{lseg_pkg::MODE_PULSE, 8'd255, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 8'd0, 0, 8'd0},
    '{lseg_pkg::MODE_STROBE, 8'd0, 16'd100, 1'b1, 32'd0, 8'd0, 1, 8'd255},
    '{lseg_pkg::MODE_STROBE, 8'd0, 16'd9, 1'b1, 32'd1, 8'd0, 1, 8'd0},      // period/10 zero
    '{lseg_pkg::MODE_CHASE, 8'd255, 16'd10, 1'b1, 32'd10, 8'd0, 1, 8'd255},
    '{lseg_pkg::MODE_CHASE, 8'd255, 16'd100, 1'b1, 32'd100, 8'd0, 0, 8'd0},
    '{lseg_pkg::MODE_HUE, 8'd240, 16'd1, 1'b1, 32'd120, 8'd0, 1, 8'd240},
    '{lseg_pkg::MODE_HUE, 8'd240, 16'd1, 1'b1, 32'd300, 8'd0, 0, 8'd0},
    '{lseg_pkg::MODE_HUE, 8'd240, 16'd1, 1'b1, 32'd359, 8'd0, 0, 8'd0},
    '{lseg_pkg::MODE_AUDIO, 8'd0, 16'd100, 1'b1, 32'd7, 8'hA5, 1, 8'hA5},
    '{lseg_pkg::MODE_AUDIO, 8'd0, 16'd100, 1'b0, 32'd7, 8'hA5, 1, 8'd0},    // disabled strip
    '{lseg_pkg::MODE_OFF, 8'd255, 16'hFFFF, 1'b1, 32'h8000_0000, 8'hFF, 1, 8'd0}
  };

  initial begin
    row_t r;
    logic [2:0] m;
    int n;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    cur_mode = lseg_pkg::MODE_STATIC;
    cur_bright = 8'd255;
    cur_period = 16'd100;
    cur_enable = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; the first row checks the reset values untouched
    foreach (rows[i]) begin
      lseg_pkg::out_item_t p;
      r = rows[i];
      if (i != 0) set_all(r.mode, r.bright, r.period, r.enable);
      p = predict_duty(r.now, r.audio);
      if (r.known && p.duty !== r.duty) begin
        $display("%0t: row %0d table expected %0d predictor %0d", $time, i,
                 r.duty, p.duty);
        errors++;
      end
      send_item(r.now, r.audio);
      send_idle();
    end

    // random phases: every mode, mixed settings, three idling profiles
    for (int ph = 0; ph < 24; ph++) begin
      if (ph < 8) begin send_gap = 11; take_gap = 60; end
      else if (ph < 16) begin send_gap = 60; take_gap = 11; end
      else begin send_gap = 0; take_gap = 0; end
      m = 3'(ph % 8);
      set_all(m, (ph % 5 == 0) ? 8'd255 : 8'($urandom_range(255)),
              (ph % 6 == 0) ? 16'hFFFF : (ph % 3 == 0) ? 16'($urandom_range(20))
                                       : 16'($urandom_range(2000)),
              (ph % 7 != 3));
      n = 66;
      for (int k = 0; k < n; k++) begin
        logic [31:0] t;
        t = $urandom();
        if (k % 3 != 0) t = t % 200000;
        send_item(t, 8'($urandom_range(255)));
        // the sender holds off once until the pipeline has emptied
        if (ph == 4 && k == 30) begin
          in_ch.valid <= 1'b0;
          while (duty_queue.size() != 0) @(posedge clk);
        end
      end
      send_idle();
    end

    drain();
    $display("drove %0d input transactions over all eight effects, checked %0d results",
             sent, checked);
    if (errors == 0) $display("led_strip_effect_generator_test OK");
    else $display("led_strip_effect_generator_test NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", duty_queue.size());
    $display("led_strip_effect_generator_test NOT OK");
    $finish;
  end
endmodule

@@ led_strip_effect_generator.f @@
hdl/lseg_pkg.sv
hdl/lseg_stream_if.sv
hdl/lseg_div.sv
hdl/lseg_shape.sv
hdl/led_strip_effect_generator.sv
hdl/lseg_checker.sv
dv/led_strip_effect_generator_test.sv
